// ----- hw/rtl/cmf_pkg.sv -----
// Shared types, widths, register codes and the saturation helper for the
// color matrix filter. No dependencies.

package cmf_pkg;

  localparam int unsigned COEF_FRAC_BITS = 12;
  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned COEF_W         = 16;
  localparam int unsigned ROW_W          = 4 * COEF_W;
  // An 8-bit channel times a signed 16-bit weight, and 255 times a weight.
  localparam int unsigned PROD_W         = CHAN_W + COEF_W + 1;
  // Four products summed.
  localparam int unsigned SUM_W          = PROD_W + 2;

  typedef enum logic [1:0] {
    REG_RED_ROW    = 2'd0,
    REG_GREEN_ROW  = 2'd1,
    REG_BLUE_ROW   = 2'd2,
    REG_ALPHA_GAIN = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] offset;
    logic signed [COEF_W-1:0] blue;
    logic signed [COEF_W-1:0] green;
    logic signed [COEF_W-1:0] red;
  } coef_row_t;

  typedef struct packed {
    coef_row_t                red_row;
    coef_row_t                green_row;
    coef_row_t                blue_row;
    logic signed [COEF_W-1:0] alpha_gain;
  } cmf_cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  localparam logic signed [COEF_W-1:0] ONE_COEF  = COEF_W'(1 << COEF_FRAC_BITS);
  localparam logic signed [COEF_W-1:0] ZERO_COEF = '0;

  localparam coef_row_t RED_ROW_RESET   = '{offset: ZERO_COEF, blue: ZERO_COEF,
                                            green: ZERO_COEF, red: ONE_COEF};
  localparam coef_row_t GREEN_ROW_RESET = '{offset: ZERO_COEF, blue: ZERO_COEF,
                                            green: ONE_COEF, red: ZERO_COEF};
  localparam coef_row_t BLUE_ROW_RESET  = '{offset: ZERO_COEF, blue: ONE_COEF,
                                            green: ZERO_COEF, red: ZERO_COEF};

  // Drops the fraction bits and saturates the result to 0..255.
  function automatic logic [CHAN_W-1:0] clamp_shift(logic signed [SUM_W-1:0] sum);
    logic [CHAN_W-1:0] res;
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (|sum[SUM_W-2:COEF_FRAC_BITS+CHAN_W]) begin
      res = '1;
    end else begin
      res = sum[COEF_FRAC_BITS+CHAN_W-1:COEF_FRAC_BITS];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/cmf_cfg_regs.sv -----
// Configuration register file: three weight rows and the alpha gain.
// Depends on cmf_pkg.

module cmf_cfg_regs
  import cmf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [ROW_W-1:0] cfg_wdata_i,
  output cmf_cfg_t         cfg_o
);

  cmf_cfg_t cfg_q;
  cmf_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_RED_ROW:    cfg_d.red_row    = cfg_wdata_i;
        REG_GREEN_ROW:  cfg_d.green_row  = cfg_wdata_i;
        REG_BLUE_ROW:   cfg_d.blue_row   = cfg_wdata_i;
        REG_ALPHA_GAIN: cfg_d.alpha_gain = cfg_wdata_i[COEF_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_row    <= RED_ROW_RESET;
      cfg_q.green_row  <= GREEN_ROW_RESET;
      cfg_q.blue_row   <= BLUE_ROW_RESET;
      cfg_q.alpha_gain <= ONE_COEF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/cmf_row_mac.sv -----
// One output channel: four weighted products summed, shifted and saturated
// into a registered 8-bit result. Depends on cmf_pkg.

module cmf_row_mac
  import cmf_pkg::*;
(
  input  logic              clk_i,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  input  coef_row_t         row_i,
  output logic [CHAN_W-1:0] chan_o
);

  logic signed [CHAN_W:0]   red_s;
  logic signed [CHAN_W:0]   green_s;
  logic signed [CHAN_W:0]   blue_s;
  logic signed [PROD_W-1:0] offset_ext;
  logic signed [PROD_W-1:0] prod [4];
  logic signed [SUM_W-1:0]  sum;
  logic [CHAN_W-1:0]        chan_q;

  assign red_s      = signed'({1'b0, red_i});
  assign green_s    = signed'({1'b0, green_i});
  assign blue_s     = signed'({1'b0, blue_i});
  assign offset_ext = PROD_W'(row_i.offset);

  always_comb begin
    prod[0] = PROD_W'(red_s) * PROD_W'(row_i.red);
    prod[1] = PROD_W'(green_s) * PROD_W'(row_i.green);
    prod[2] = PROD_W'(blue_s) * PROD_W'(row_i.blue);
    // The offset is scaled by 255, done as a shift and a subtract.
    prod[3] = (offset_ext <<< CHAN_W) - offset_ext;
  end

  assign sum = SUM_W'(prod[0]) + SUM_W'(prod[1])
             + SUM_W'(prod[2]) + SUM_W'(prod[3]);

  always_ff @(posedge clk_i) begin
    chan_q <= clamp_shift(sum);
  end

  assign chan_o = chan_q;

endmodule

// ----- hw/rtl/color_matrix_filter.sv -----
// Color matrix filter top level: input register, four channel datapaths,
// valid pipeline and the configuration registers. Depends on cmf_pkg,
// cmf_cfg_regs and cmf_row_mac.
//
// Usage: a pixel request is taken at a rising clock edge where start is
// high and busy is low. busy stays low, so a new pixel may be sent in every
// cycle and the block sustains one pixel per clock. Each pixel passes two
// register stages (input register, result register) before its result is
// on the outputs with done_o high for exactly one cycle; results leave in
// request order. The receiver cannot stall the block and must take each
// result when done_o is high. Weights are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i, one register per edge; the user must write
// them only while no pixel is in flight, which the block does not enforce.
// Reset clears the valid pipeline and loads the identity matrix with an
// alpha gain of 1.0.

module color_matrix_filter
  import cmf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CHAN_W-1:0] red_in_i,
  input  logic [CHAN_W-1:0] green_in_i,
  input  logic [CHAN_W-1:0] blue_in_i,
  input  logic [CHAN_W-1:0] alpha_in_i,
  output logic              done_o,
  output logic [CHAN_W-1:0] red_out_o,
  output logic [CHAN_W-1:0] green_out_o,
  output logic [CHAN_W-1:0] blue_out_o,
  output logic [CHAN_W-1:0] alpha_out_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [ROW_W-1:0]  cfg_wdata_i
);

  cmf_cfg_t  cfg;
  pixel_t    pix_q;
  logic      req_accept;
  logic [1:0] valid_q;
  coef_row_t alpha_row;

  assign busy       = 1'b0;
  assign req_accept = start && !busy;

  cmf_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[0], req_accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      pix_q <= '{alpha: alpha_in_i, blue: blue_in_i, green: green_in_i, red: red_in_i};
    end
  end

  cmf_row_mac u_red_mac (
    .clk_i   (clk_i),
    .red_i   (pix_q.red),
    .green_i (pix_q.green),
    .blue_i  (pix_q.blue),
    .row_i   (cfg.red_row),
    .chan_o  (red_out_o)
  );

  cmf_row_mac u_green_mac (
    .clk_i   (clk_i),
    .red_i   (pix_q.red),
    .green_i (pix_q.green),
    .blue_i  (pix_q.blue),
    .row_i   (cfg.green_row),
    .chan_o  (green_out_o)
  );

  cmf_row_mac u_blue_mac (
    .clk_i   (clk_i),
    .red_i   (pix_q.red),
    .green_i (pix_q.green),
    .blue_i  (pix_q.blue),
    .row_i   (cfg.blue_row),
    .chan_o  (blue_out_o)
  );

  // Alpha reuses the channel datapath with only one nonzero weight.
  assign alpha_row = '{offset: ZERO_COEF, blue: ZERO_COEF,
                       green: ZERO_COEF, red: cfg.alpha_gain};

  cmf_row_mac u_alpha_mac (
    .clk_i   (clk_i),
    .red_i   (pix_q.alpha),
    .green_i ('0),
    .blue_i  ('0),
    .row_i   (alpha_row),
    .chan_o  (alpha_out_o)
  );

  assign done_o = valid_q[1];

`ifndef SYNTHESIS
  a_req_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |-> ##2 done_o)
    else $error("accepted pixel request did not produce a result");

  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_accept, 2))
    else $error("result strobe without a matching pixel request");

  a_no_cfg_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !(|valid_q))
    else $error("configuration written while a pixel is in flight");
`endif

endmodule

// ----- sim/color_matrix_filter_test.sv -----
// Self-checking testbench for color_matrix_filter: directed pixels and register
// extremes, then randomized weight settings and pixel streams with idle gaps.
// Depends on cmf_pkg and the color_matrix_filter RTL.
`timescale 1ns / 100ps

module color_matrix_filter_test;
  import cmf_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned RAND_PHASES  = 9;
  localparam int unsigned PHASE_PIXELS = 100;

  typedef enum logic {
    ROW_PIXEL = 1'b0,
    ROW_WRITE = 1'b1
  } row_kind_e;

  // One directed step: either a register write or a pixel request. Pixels
  // are written as {alpha, blue, green, red}.
  typedef struct packed {
    row_kind_e          kind;
    cfg_idx_e           idx;
    logic [ROW_W-1:0]   data;
    pixel_t             px;
    logic               typed;
    pixel_t             want;
  } stim_row_t;

  localparam int unsigned NUM_DIRECTED = 30;

  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // Identity matrix after reset: every pixel comes back unchanged.
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h00000000, 1'b1, 32'h00000000},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'hffffffff, 1'b1, 32'hffffffff},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'hf00faa55, 1'b1, 32'hf00faa55},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h0ff055aa, 1'b1, 32'h0ff055aa},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h80402010, 1'b1, 32'h80402010},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h7f7f7f7f, 1'b0, 32'h0},
    // Largest positive weights everywhere: red saturates high even for black.
    '{ROW_WRITE, REG_RED_ROW,    64'h7fff7fff7fff7fff, 32'h0, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h00000000, 1'b1, 32'h000000ff},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h01010101, 1'b1, 32'h010101ff},
    // Most negative weights: green clamps to zero.
    '{ROW_WRITE, REG_GREEN_ROW,  64'h8000800080008000, 32'h0, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'hffffffff, 1'b1, 32'hffff00ff},
    // Offset of 1.0 alone drives blue to full scale.
    '{ROW_WRITE, REG_BLUE_ROW,   64'h1000000000000000, 32'h0, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h281e140a, 1'b1, 32'h28ff00ff},
    // Negative alpha gain; the upper data bits must not matter.
    '{ROW_WRITE, REG_ALPHA_GAIN, 64'hffffffffffff8000, 32'h0, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'hc8030201, 1'b1, 32'h00ff00ff},
    '{ROW_WRITE, REG_ALPHA_GAIN, 64'h0000000000007fff, 32'h0, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h01000000, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'hff000000, 1'b0, 32'h0},
    '{ROW_WRITE, REG_RED_ROW,    64'h0, 32'h0, 1'b0, 32'h0},
    '{ROW_WRITE, REG_GREEN_ROW,  64'h0000080008000800, 32'h0, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h605a3c1e, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'hffffffff, 1'b0, 32'h0},
    // Blue is 2*b - 255: just below and just above the zero crossing, then full scale.
    '{ROW_WRITE, REG_BLUE_ROW,   64'hf000200000000000, 32'h0, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h007f0000, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h00800000, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h00ff0000, 1'b0, 32'h0},
    // Tiny weights exercise truncation of the fraction bits.
    '{ROW_WRITE, REG_RED_ROW,    64'h0000000000000001, 32'h0, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'h000000ff, 1'b0, 32'h0},
    '{ROW_WRITE, REG_ALPHA_GAIN, 64'h0000000000000800, 32'h0, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_RED_ROW,    64'h0, 32'hff000000, 1'b0, 32'h0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [CHAN_W-1:0] red_in_i;
  logic [CHAN_W-1:0] green_in_i;
  logic [CHAN_W-1:0] blue_in_i;
  logic [CHAN_W-1:0] alpha_in_i;
  logic             done_o;
  logic [CHAN_W-1:0] red_out_o;
  logic [CHAN_W-1:0] green_out_o;
  logic [CHAN_W-1:0] blue_out_o;
  logic [CHAN_W-1:0] alpha_out_o;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [ROW_W-1:0] cfg_wdata_i;

  cmf_cfg_t weights;
  pixel_t   expected_pixels[$];
  int       error_count;
  int       pixels_sent;
  int       pixels_checked;
  int       settings_used;

  color_matrix_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .alpha_in_i  (alpha_in_i),
    .done_o      (done_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .alpha_out_o (alpha_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [CHAN_W-1:0] saturate(longint sum);
    longint q;
    if (sum < 0) begin
      return '0;
    end
    q = sum >>> COEF_FRAC_BITS;
    return (q > 255) ? 8'd255 : q[CHAN_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] weigh_row(coef_row_t row, pixel_t px);
    longint sum;
    sum = longint'(px.red)   * longint'($signed(row.red))
        + longint'(px.green) * longint'($signed(row.green))
        + longint'(px.blue)  * longint'($signed(row.blue))
        + 64'sd255           * longint'($signed(row.offset));
    return saturate(sum);
  endfunction

  function automatic pixel_t filter_pixel(pixel_t px);
    pixel_t res;
    res.red   = weigh_row(weights.red_row, px);
    res.green = weigh_row(weights.green_row, px);
    res.blue  = weigh_row(weights.blue_row, px);
    res.alpha = saturate(longint'(px.alpha) * longint'($signed(weights.alpha_gain)));
    return res;
  endfunction

  function automatic logic [COEF_W-1:0] random_coef(int unsigned mode);
    logic [COEF_W-1:0] pick [5];
    int                v;
    pick = '{16'h7fff, 16'h8000, 16'h0000, 16'h1000, 16'hf000};
    case (mode)
      0: v = $urandom();
      1: v = int'($urandom_range(0, 12288)) - 4096;
      default: v = pick[$urandom_range(0, 4)];
    endcase
    return v[COEF_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] random_row(int unsigned mode);
    logic [COEF_W-1:0] off;
    // Offsets stay modest in mode 1, within -512..512.
    off = (mode == 1) ? COEF_W'(int'($urandom_range(0, 1024)) - 512) : random_coef(mode);
    return {off, random_coef(mode), random_coef(mode), random_coef(mode)};
  endfunction

  task automatic check_field(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && done_o) begin
      if (expected_pixels.size() == 0) begin
        $error("result with no pixel request outstanding");
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red_out", want.red, red_out_o);
        check_field("green_out", want.green, green_out_o);
        check_field("blue_out", want.blue, blue_out_o);
        check_field("alpha_out", want.alpha, alpha_out_o);
        pixels_checked++;
      end
    end
  end

  // Lets every outstanding pixel come back before the weights change.
  task automatic drain();
    start    <= 1'b0;
    cfg_we_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [ROW_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_RED_ROW:    weights.red_row    = data;
      REG_GREEN_ROW:  weights.green_row  = data;
      REG_BLUE_ROW:   weights.blue_row   = data;
      REG_ALPHA_GAIN: weights.alpha_gain = data[COEF_W-1:0];
      default: ;
    endcase
    settings_used++;
  endtask

  task automatic send_pixel(pixel_t px, logic typed, pixel_t want);
    cfg_we_i   <= 1'b0;
    start      <= 1'b1;
    red_in_i   <= px.red;
    green_in_i <= px.green;
    blue_in_i  <= px.blue;
    alpha_in_i <= px.alpha;
    do @(posedge clk_i); while (busy);
    expected_pixels.push_back(typed ? want : filter_pixel(px));
    pixels_sent++;
  endtask

  initial begin
    int unsigned idle_pct [3];
    int unsigned idle_pct_now;
    int unsigned mode;
    pixel_t      px;
    idle_pct       = '{0, 57, 13};
    error_count    = 0;
    pixels_sent    = 0;
    pixels_checked = 0;
    settings_used  = 0;
    weights        = '{red_row: RED_ROW_RESET, green_row: GREEN_ROW_RESET,
                       blue_row: BLUE_ROW_RESET, alpha_gain: ONE_COEF};
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    red_in_i    <= '0;
    green_in_i  <= '0;
    blue_in_i   <= '0;
    alpha_in_i  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_RED_ROW;
    cfg_wdata_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        drain();
        write_cfg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      idle_pct_now = idle_pct[ph % 3];
      mode         = (ph / 3) % 3;
      drain();
      write_cfg(REG_RED_ROW, random_row(mode));
      write_cfg(REG_GREEN_ROW, random_row(mode));
      write_cfg(REG_BLUE_ROW, random_row(mode));
      // Random upper bits ride along with the 16-bit alpha gain.
      write_cfg(REG_ALPHA_GAIN, {$urandom(), $urandom()} & ~64'hffff | 64'(random_coef(mode)));
      for (int unsigned n = 0; n < PHASE_PIXELS; n++) begin
        px = $urandom();
        send_pixel(px, 1'b0, '0);
        if ($urandom_range(0, 99) < idle_pct_now) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
    end

    drain();
    $display("Checked %0d of %0d pixels across %0d register writes, %0d mismatches.",
             pixels_checked, pixels_sent, settings_used, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/cmf_pkg.sv
hw/rtl/cmf_cfg_regs.sv
hw/rtl/cmf_row_mac.sv
hw/rtl/color_matrix_filter.sv
sim/color_matrix_filter_test.sv
